// ===== hdl/scbr_pkg.sv =====
// ----------------------------------------------------------------------------
// scbr_pkg
// Shared types and codes of the size-class block recycler.
// ----------------------------------------------------------------------------
package scbr_pkg;

  localparam int CMD_W    = 2;
  localparam int SIZE_W   = 16;
  localparam int HANDLE_W = 32;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [SIZE_W-1:0]   blk_size_t;
  typedef logic [HANDLE_W-1:0] handle_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam cmd_t CMD_CHECK = 2'd0;
  localparam cmd_t CMD_GET   = 2'd1;
  localparam cmd_t CMD_PUT   = 2'd2;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_TOO_LARGE = 2'd1;
  localparam status_t ST_NONE      = 2'd2;
  localparam status_t ST_FULL      = 2'd3;

endpackage

// ===== hdl/scbr_if.sv =====
// ----------------------------------------------------------------------------
// scbr_in_if / scbr_out_if
// Valid/ready channels that carry request words and result words.
// ----------------------------------------------------------------------------
interface scbr_in_if;
  import scbr_pkg::*;

  logic      valid;
  logic      ready;
  cmd_t      command;
  blk_size_t block_size;
  handle_t   block_handle;

  modport source (output valid, output command, output block_size, output block_handle,
                  input ready);
  modport sink (input valid, input command, input block_size, input block_handle,
                output ready);
endinterface

interface scbr_out_if;
  import scbr_pkg::*;

  logic    valid;
  logic    ready;
  count_t  block_count;
  handle_t handle_out;
  status_t status;

  modport source (output valid, output block_count, output handle_out, output status,
                  input ready);
  modport sink (input valid, input block_count, input handle_out, input status,
                output ready);
endinterface

// ===== hdl/scbr_ram.sv =====
// ----------------------------------------------------------------------------
// scbr_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module scbr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/size_class_block_recycler_top.sv =====
// ----------------------------------------------------------------------------
// size_class_block_recycler_top
// Keeps freed block handles on one stack per size class.
// ----------------------------------------------------------------------------
// A check, a put or a get that finds nothing is resolved in the lookup state and
// written straight to the result register; a get that pops a handle goes on
// to a read state, as the handle memory gives its read data registered.
// A new request word is accepted once the previous one has been resolved; a
// waiting result word in the output register stalls only the final step. The
// class table (valid bits, size tags and counts) sits in flip-flops and is
// matched in parallel; handles live in one memory of SIZE_CLASSES stacks, each
// STACK_DEPTH deep rounded up to a power of two. No clearing pass is needed
// after reset.
module size_class_block_recycler_top #(
  parameter int SIZE_CLASSES   = 16,
  parameter int STACK_DEPTH    = 64,
  parameter int HANDLE_BITS    = 32,
  parameter int MAX_BLOCK_SIZE = 2048
) (
  input logic clk,
  input logic rst_n,
  scbr_in_if.sink    in_ch,
  scbr_out_if.source out_ch
);
  import scbr_pkg::*;

  localparam int CLS_W     = SIZE_CLASSES > 1 ? $clog2(SIZE_CLASSES) : 1;
  localparam int PTR_W     = STACK_DEPTH > 1 ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int RAM_AW    = CLS_W + PTR_W;
  localparam int RAM_DEPTH = 1 << RAM_AW;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [1:0]             state_r, state_nxt;
  cmd_t                   cmd_r;
  blk_size_t              size_r;
  logic [HANDLE_BITS-1:0] handle_r;

  logic                   valid_r [SIZE_CLASSES];
  blk_size_t              tag_r   [SIZE_CLASSES];
  logic [CNT_W-1:0]       cnt_r   [SIZE_CLASSES];

  logic                   out_valid_r, out_valid_nxt;
  count_t                 out_cnt_r, out_cnt_nxt;
  handle_t                out_handle_r, out_handle_nxt;
  status_t                out_status_r, out_status_nxt;
  logic [CNT_W-1:0]       get_cnt_r, get_cnt_nxt;
  logic [RAM_AW-1:0]      rd_addr_r, rd_addr_nxt;

  logic [SIZE_CLASSES-1:0] match;
  logic                    hit, have_free;
  logic [CLS_W-1:0]        hit_idx, free_idx, put_idx;
  logic [CNT_W-1:0]        cur_cnt, put_base;
  logic                    in_acc, out_free;

  logic                    tbl_en, tbl_claim;
  logic [CLS_W-1:0]        tbl_idx;
  logic [CNT_W-1:0]        tbl_cnt;

  logic                    ram_wr_en;
  logic [RAM_AW-1:0]       ram_wr_addr, ram_rd_addr;
  logic [HANDLE_BITS-1:0]  ram_rd_data;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    hit       = 1'b0;
    have_free = 1'b0;
    hit_idx   = '0;
    free_idx  = '0;
    for (int i = SIZE_CLASSES - 1; i >= 0; i--) begin
      match[i] = valid_r[i] && (tag_r[i] == size_r);
      if (match[i]) begin
        hit     = 1'b1;
        hit_idx = CLS_W'(i);
      end
      if (!valid_r[i]) begin
        have_free = 1'b1;
        free_idx  = CLS_W'(i);
      end
    end
  end

  assign cur_cnt  = cnt_r[hit_idx];
  assign put_idx  = hit ? hit_idx : free_idx;
  assign put_base = hit ? cur_cnt : '0;

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_cnt_nxt    = out_cnt_r;
    out_handle_nxt = out_handle_r;
    out_status_nxt = out_status_r;
    get_cnt_nxt    = get_cnt_r;
    rd_addr_nxt    = rd_addr_r;
    ram_rd_addr    = rd_addr_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = {put_idx, put_base[PTR_W-1:0]};
    tbl_en         = 1'b0;
    tbl_claim      = 1'b0;
    tbl_idx        = put_idx;
    tbl_cnt        = put_base + CNT_W'(1);

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (cmd_r == CMD_GET) begin
          if (hit && (cur_cnt != '0)) begin
            tbl_en      = 1'b1;
            tbl_idx     = hit_idx;
            tbl_cnt     = cur_cnt - CNT_W'(1);
            get_cnt_nxt = tbl_cnt;
            ram_rd_addr = {hit_idx, tbl_cnt[PTR_W-1:0]};
            rd_addr_nxt = ram_rd_addr;
            state_nxt   = S_READ;
          end else if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_cnt_nxt    = '0;
            out_handle_nxt = '0;
            out_status_nxt = ST_NONE;
            state_nxt      = S_IDLE;
          end
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_handle_nxt = '0;
          out_status_nxt = ST_OK;
          out_cnt_nxt    = '0;
          state_nxt      = S_IDLE;
          if (cmd_r == CMD_PUT) begin
            if (!hit && !have_free) begin
              out_status_nxt = ST_FULL;
            end else if (put_base >= CNT_W'(STACK_DEPTH)) begin
              out_status_nxt = ST_FULL;
              out_cnt_nxt    = COUNT_W'(put_base);
            end else begin
              ram_wr_en   = 1'b1;
              tbl_en      = 1'b1;
              tbl_claim   = !hit;
              out_cnt_nxt = COUNT_W'(tbl_cnt);
            end
          end else begin
            if (size_r > SIZE_W'(MAX_BLOCK_SIZE)) begin
              out_status_nxt = ST_TOO_LARGE;
            end else if (hit) begin
              out_cnt_nxt = COUNT_W'(cur_cnt);
            end
          end
        end
      end
      S_READ: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_cnt_nxt    = COUNT_W'(get_cnt_r);
          out_handle_nxt = HANDLE_W'(ram_rd_data);
          out_status_nxt = ST_OK;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SIZE_CLASSES; i++) begin
        valid_r[i] <= 1'b0;
        cnt_r[i]   <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (tbl_en) begin
        cnt_r[tbl_idx] <= tbl_cnt;
      end
      if (tbl_claim) begin
        valid_r[tbl_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r    <= in_ch.command;
      size_r   <= in_ch.block_size;
      handle_r <= HANDLE_BITS'(in_ch.block_handle);
    end
    if (tbl_claim) begin
      tag_r[tbl_idx] <= size_r;
    end
    out_cnt_r    <= out_cnt_nxt;
    out_handle_r <= out_handle_nxt;
    out_status_r <= out_status_nxt;
    get_cnt_r    <= get_cnt_nxt;
    rd_addr_r    <= rd_addr_nxt;
  end

  scbr_ram #(
    .WIDTH (HANDLE_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_handle_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (handle_r),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.block_count = out_cnt_r;
  assign out_ch.handle_out  = out_handle_r;
  assign out_ch.status      = out_status_r;

`ifndef SYNTHESIS
  a_one_class_per_size: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match))
    else $error("More than one class entry holds the same size.");

  a_read_only_for_get: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> (cmd_r == CMD_GET))
    else $error("Handle memory read step entered for a command other than get.");

  a_accept_starts_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_LOOK))
    else $error("Accepted word did not move on to the class lookup.");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOK) |-> (cur_cnt <= CNT_W'(STACK_DEPTH)))
    else $error("Class count exceeds the stack depth.");
`endif

endmodule
